// ===== hw/rtl/ccc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg: calendar clock constants and helpers
// Operation and status codes, unit limits, reset time, month length table and the
// Gregorian leap year test.
// ----------------------------------------------------------------------------
package ccc_pkg;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic ST_OK     = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	localparam logic [5:0] SEC_TOP  = 6'd60;
	localparam logic [5:0] MIN_TOP  = 6'd60;
	localparam logic [4:0] HOUR_TOP = 5'd24;
	localparam logic [3:0] MON_TOP  = 4'd12;
	localparam logic [3:0] MON_FEB  = 4'd2;

	localparam logic [15:0] RST_YEAR   = 16'd2222;
	localparam logic [3:0]  RST_MONTH  = 4'd2;
	localparam logic [4:0]  RST_DAY    = 5'd22;
	localparam logic [4:0]  RST_HOUR   = 5'd2;
	localparam logic [5:0]  RST_MINUTE = 6'd2;
	localparam logic [5:0]  RST_SECOND = 6'd2;

	// 25 * INV25 == 1 mod 2**16; y is a multiple of 25 when y * INV25 (mod 2**16)
	// lands at or below 65535 / 25
	localparam logic [15:0] INV25     = 16'h5C29;
	localparam logic [15:0] DIV25_MAX = 16'(65535 / 25);

	typedef logic [4:0] mlen_tab_t [12];
	localparam mlen_tab_t MONTH_LEN = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// divisible by 4 and not by 100, or by 400 (= by 16 and by 25)
	function automatic logic is_leap(input logic [15:0] year);
		logic [31:0] prod;
		logic        by25;
		prod = 32'(year) * 32'(INV25);
		by25 = (prod[15:0] <= DIV25_MAX);
		return ((year[1:0] == 2'd0) && !by25) || ((year[3:0] == 4'd0) && by25);
	endfunction

	// zero for a month outside 1..12
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [3:0] idx;
		logic [4:0] len;
		idx = month - 4'd1;
		if (month == 4'd0 || month > MON_TOP) begin
			len = 5'd0;
		end else begin
			len = MONTH_LEN[idx];
			if (month == MON_FEB && leap) begin
				len = len + 5'd1;
			end
		end
		return len;
	endfunction

endpackage

// ===== hw/rtl/calendar_clock_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_counter: real-time clock with calendar
// Takes one-second ticks or full date/time loads, keeps Gregorian date and
// time of day, and returns the time after every word together with a status.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  cmd     | in        | cmd_valid / cmd_stall | opcode, load_year .. load_second
//  rsp     | out       | rsp_valid / rsp_stall | cur_year .. cur_second, status
//
//  One word per cycle sustained while rsp_stall is low; a word taken passes
//  through the input register, then the result register.
//  The carry chain and the month length lookup sit between the input
//  register and the result register; the state updates as the result loads.
//  Reset sets 2222-02-22 02:02:02 and empties both stages.
//  A stalled result holds; one more word waits in the input register, then
//  cmd_stall rises.
// ----------------------------------------------------------------------------
module calendar_clock_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        opcode,
	input  logic [15:0] load_year,
	input  logic [3:0]  load_month,
	input  logic [4:0]  load_day,
	input  logic [4:0]  load_hour,
	input  logic [5:0]  load_minute,
	input  logic [5:0]  load_second,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] cur_year,
	output logic [3:0]  cur_month,
	output logic [4:0]  cur_day,
	output logic [4:0]  cur_hour,
	output logic [5:0]  cur_minute,
	output logic [5:0]  cur_second,
	output logic        status
);
	import ccc_pkg::*;

	// input register
	logic        valid_s1;
	logic        op_s1;
	logic [15:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;
	logic [5:0]  second_s1;
	logic        leap_s1;

	// clock state
	logic [15:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic        leap_q;

	// result register
	logic        rsp_valid_q;
	logic [15:0] rsp_year_q;
	logic [3:0]  rsp_month_q;
	logic [4:0]  rsp_day_q;
	logic [4:0]  rsp_hour_q;
	logic [5:0]  rsp_minute_q;
	logic [5:0]  rsp_second_q;
	logic        rsp_status_q;

	logic        adv;
	logic        take;

	logic [15:0] nx_year;
	logic [3:0]  nx_month;
	logic [4:0]  nx_day;
	logic [4:0]  nx_hour;
	logic [5:0]  nx_minute;
	logic [5:0]  nx_second;
	logic        nx_leap;
	logic        nx_status;

	logic [5:0]  sec_inc;
	logic [5:0]  min_inc;
	logic [4:0]  hour_inc;
	logic [3:0]  mon_inc;
	logic [15:0] year_inc;
	logic [4:0]  cur_len;
	logic [4:0]  load_len;
	logic        load_bad;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = valid_s1 && !adv;
	assign take      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1     <= opcode;
			year_s1   <= load_year;
			month_s1  <= load_month;
			day_s1    <= load_day;
			hour_s1   <= load_hour;
			minute_s1 <= load_minute;
			second_s1 <= load_second;
			leap_s1   <= is_leap(load_year);
		end
	end

	always_comb begin
		sec_inc  = second_q + 6'd1;
		min_inc  = minute_q + 6'd1;
		hour_inc = hour_q + 5'd1;
		mon_inc  = month_q + 4'd1;
		year_inc = year_q + 16'd1;
		cur_len  = month_len(month_q, leap_q);
		load_len = month_len(month_s1, leap_s1);
		load_bad = (load_len == 5'd0) || (day_s1 == 5'd0) || (day_s1 > load_len) ||
			(hour_s1 >= HOUR_TOP) || (minute_s1 >= MIN_TOP) || (second_s1 >= SEC_TOP);

		nx_year   = year_q;
		nx_month  = month_q;
		nx_day    = day_q;
		nx_hour   = hour_q;
		nx_minute = minute_q;
		nx_second = second_q;
		nx_leap   = leap_q;
		nx_status = ST_OK;

		if (op_s1 == OP_LOAD) begin
			if (load_bad) begin
				nx_status = ST_REJECT;
			end else begin
				nx_year   = year_s1;
				nx_month  = month_s1;
				nx_day    = day_s1;
				nx_hour   = hour_s1;
				nx_minute = minute_s1;
				nx_second = second_s1;
				nx_leap   = leap_s1;
			end
		end else begin
			nx_second = sec_inc;
			if (sec_inc >= SEC_TOP) begin
				nx_second = 6'd0;
				nx_minute = min_inc;
				if (min_inc >= MIN_TOP) begin
					nx_minute = 6'd0;
					nx_hour   = hour_inc;
					if (hour_inc >= HOUR_TOP) begin
						nx_hour = 5'd0;
						// advance the day; roll month and year at the ends
						if (day_q >= cur_len) begin
							nx_day   = 5'd1;
							nx_month = mon_inc;
							if (mon_inc > MON_TOP || mon_inc == 4'd0) begin
								nx_month = 4'd1;
								nx_year  = year_inc;
								nx_leap  = is_leap(year_inc);
							end
						end else begin
							nx_day = day_q + 5'd1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q      <= RST_YEAR;
			month_q     <= RST_MONTH;
			day_q       <= RST_DAY;
			hour_q      <= RST_HOUR;
			minute_q    <= RST_MINUTE;
			second_q    <= RST_SECOND;
			leap_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				year_q   <= nx_year;
				month_q  <= nx_month;
				day_q    <= nx_day;
				hour_q   <= nx_hour;
				minute_q <= nx_minute;
				second_q <= nx_second;
				leap_q   <= nx_leap;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rsp_year_q   <= nx_year;
			rsp_month_q  <= nx_month;
			rsp_day_q    <= nx_day;
			rsp_hour_q   <= nx_hour;
			rsp_minute_q <= nx_minute;
			rsp_second_q <= nx_second;
			rsp_status_q <= nx_status;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign cur_year   = rsp_year_q;
	assign cur_month  = rsp_month_q;
	assign cur_day    = rsp_day_q;
	assign cur_hour   = rsp_hour_q;
	assign cur_minute = rsp_minute_q;
	assign cur_second = rsp_second_q;
	assign status     = rsp_status_q;

endmodule
